>>> design/hhct_pkg.sv
package hhct_pkg;

  localparam int SLOTS      = 32;
  localparam int COUNT_BITS = 32;
  localparam int KEY_BITS   = 64;
  localparam int SLOT_W     = $clog2(SLOTS);

  localparam int OUT_SLOT_BITS  = 5;
  localparam int OUT_COUNT_BITS = 32;

  typedef logic [KEY_BITS-1:0]   key_t;
  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [SLOT_W-1:0]     slot_idx_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
    logic reject;
  } hhct_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic elem_zero;
    logic scan_last;
  } hhct_status_t;

  // saturating increment of a slot count
  function automatic count_t count_inc(input count_t c);
    count_t r;
    r = (c == {COUNT_BITS{1'b1}}) ? c : c + count_t'(1);
    return r;
  endfunction

  // result count field saturates when the count is wider than the field
  function automatic logic [OUT_COUNT_BITS-1:0] count_out(input count_t c);
    logic [63:0] w;
    w = 64'(c);
    return (w > 64'(32'hFFFF_FFFF)) ? {OUT_COUNT_BITS{1'b1}} : w[OUT_COUNT_BITS-1:0];
  endfunction

  // result slot field carries the low bits of the slot index
  function automatic logic [OUT_SLOT_BITS-1:0] slot_out(input slot_idx_t s);
    logic [31:0] w;
    w = 32'(s);
    return w[OUT_SLOT_BITS-1:0];
  endfunction

endpackage

>>> design/hhct_ctrl.sv
module hhct_ctrl import hhct_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start,
  output logic         busy,
  input  hhct_status_t status_i,
  output hhct_cmd_t    cmd_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_WRITE = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status_i.elem_zero) begin
          cmd_o.reject = 1'b1;
          state_d      = ST_IDLE;
        end else begin
          cmd_o.scan = 1'b1;
          if (status_i.scan_last) begin
            state_d = ST_WRITE;
          end
        end
      end
      ST_WRITE: begin
        cmd_o.commit = 1'b1;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != ST_IDLE);

`ifndef ASSERT_OFF
  // a write pass always follows a completed scan
  a_write_after_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_WRITE |-> $past(state_q) == ST_SCAN && $past(status_i.scan_last))
    else $error("write state entered without a finished scan");

  // only one command at a time
  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd_o))
    else $error("more than one datapath command");
`endif

endmodule

>>> design/hhct_datapath.sv
module hhct_datapath import hhct_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [KEY_BITS-1:0]       element_i,
  input  hhct_cmd_t                 cmd_i,
  output hhct_status_t              status_o,
  output logic                      result_valid_o,
  output logic [OUT_SLOT_BITS-1:0]  slot_o,
  output logic [OUT_COUNT_BITS-1:0] new_count_o,
  output logic                      evicted_o,
  output logic [KEY_BITS-1:0]       evicted_element_o,
  output logic                      rejected_o
);

  key_t      key_q [SLOTS];
  count_t    cnt_q [SLOTS];

  key_t      elem_q;
  slot_idx_t scan_idx_q;
  logic      hit_q;
  slot_idx_t hit_idx_q;
  count_t    hit_cnt_q;
  slot_idx_t min_idx_q;
  count_t    min_cnt_q;
  key_t      min_key_q;

  logic                      valid_q;
  logic [OUT_SLOT_BITS-1:0]  slot_q;
  logic [OUT_COUNT_BITS-1:0] count_out_q;
  logic                      evicted_q;
  key_t                      evicted_key_q;
  logic                      rejected_q;

  key_t      cur_key;
  count_t    cur_cnt;
  logic      match;
  logic      take_min;
  slot_idx_t sel_idx;
  count_t    sel_cnt;
  count_t    upd_cnt;
  logic      evict;

  assign cur_key  = key_q[scan_idx_q];
  assign cur_cnt  = cnt_q[scan_idx_q];
  assign match    = (cur_key == elem_q);
  // strict compare keeps the lowest index on ties
  assign take_min = (scan_idx_q == '0) || (cur_cnt < min_cnt_q);

  assign sel_idx = hit_q ? hit_idx_q : min_idx_q;
  assign sel_cnt = hit_q ? hit_cnt_q : min_cnt_q;
  assign upd_cnt = count_inc(sel_cnt);
  assign evict   = !hit_q && (min_key_q != '0);

  assign status_o.elem_zero = (elem_q == '0);
  assign status_o.scan_last = (scan_idx_q == SLOT_W'(SLOTS - 1));

  // slot table
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        key_q[i] <= '0;
        cnt_q[i] <= '0;
      end
    end else if (cmd_i.commit) begin
      key_q[sel_idx] <= elem_q;
      cnt_q[sel_idx] <= upd_cnt;
    end
  end

  // scan registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      elem_q     <= element_i;
      scan_idx_q <= '0;
      hit_q      <= 1'b0;
    end else if (cmd_i.scan) begin
      scan_idx_q <= scan_idx_q + slot_idx_t'(1);
      if (!hit_q && match) begin
        hit_q     <= 1'b1;
        hit_idx_q <= scan_idx_q;
        hit_cnt_q <= cur_cnt;
      end
      if (take_min) begin
        min_idx_q <= scan_idx_q;
        min_cnt_q <= cur_cnt;
        min_key_q <= cur_key;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.commit || cmd_i.reject;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      slot_q        <= slot_out(sel_idx);
      count_out_q   <= count_out(upd_cnt);
      evicted_q     <= evict;
      evicted_key_q <= evict ? min_key_q : '0;
      rejected_q    <= 1'b0;
    end else if (cmd_i.reject) begin
      slot_q        <= '0;
      count_out_q   <= '0;
      evicted_q     <= 1'b0;
      evicted_key_q <= '0;
      rejected_q    <= 1'b1;
    end
  end

  assign result_valid_o    = valid_q;
  assign slot_o            = slot_q;
  assign new_count_o       = count_out_q;
  assign evicted_o         = evicted_q;
  assign evicted_element_o = evicted_key_q;
  assign rejected_o        = rejected_q;

`ifndef ASSERT_OFF
  a_reject_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && rejected_q |-> count_out_q == '0 && !evicted_q && slot_q == '0)
    else $error("rejected result carries update fields");

  a_evict_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && evicted_q |-> evicted_key_q != '0)
    else $error("eviction reported with empty key");

  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !rejected_q |-> count_out_q != '0)
    else $error("updated slot reports zero count");

  a_commit_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> elem_q != '0)
    else $error("reserved element written into table");
`endif

endmodule

>>> design/heavy_hitter_counter_table_core.sv
// Frequent-item counter table with SLOTS slots (64-bit key, saturating count).
// A request is taken when start is high and busy is low. A nonzero element
// is scanned against one slot per clock, matching keys and tracking the
// smallest count (lowest index wins ties), then a write state updates the slot;
// busy stays high through the scan and the write, and a new request is taken
// only once busy is low again. A zero element is rejected from the scan state
// without a write. The result appears in the first cycle with busy low, for a
// single cycle with result_valid_o high; it must be captured then, as the block
// cannot be held off. Reset empties all slots.
module heavy_hitter_counter_table_core import hhct_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [KEY_BITS-1:0]       element_i,
  output logic                      result_valid_o,
  output logic [OUT_SLOT_BITS-1:0]  slot_o,
  output logic [OUT_COUNT_BITS-1:0] new_count_o,
  output logic                      evicted_o,
  output logic [KEY_BITS-1:0]       evicted_element_o,
  output logic                      rejected_o
);

  hhct_cmd_t    cmd;
  hhct_status_t status;

  hhct_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .status_i (status),
    .cmd_o    (cmd)
  );

  hhct_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .element_i         (element_i),
    .cmd_i             (cmd),
    .status_o          (status),
    .result_valid_o    (result_valid_o),
    .slot_o            (slot_o),
    .new_count_o       (new_count_o),
    .evicted_o         (evicted_o),
    .evicted_element_o (evicted_element_o),
    .rejected_o        (rejected_o)
  );

endmodule
